// ===== design/tcpop_pkg.sv =====
// shared types and constants for the tcp option parser
package tcpop_pkg;

    // walk phase of the option area
    typedef enum logic [2:0] {
        PH_KIND  = 3'd0,
        PH_LEN   = 3'd1,
        PH_VALUE = 3'd2,
        PH_OK    = 3'd3,
        PH_FAIL  = 3'd4
    } phase_t;

    // option kinds
    localparam logic [7:0] KIND_END   = 8'd0;
    localparam logic [7:0] KIND_NOP   = 8'd1;
    localparam logic [7:0] KIND_MSS   = 8'd2;
    localparam logic [7:0] KIND_WSCALE = 8'd3;
    localparam logic [7:0] KIND_SACKOK = 8'd4;
    localparam logic [7:0] KIND_STAMP = 8'd8;

    // option lengths that are captured
    localparam logic [5:0] LEN_MSS    = 6'd4;
    localparam logic [5:0] LEN_WSCALE = 6'd3;
    localparam logic [5:0] LEN_SACKOK = 6'd2;
    localparam logic [5:0] LEN_STAMP  = 6'd10;

    // smallest legal length byte, and header length without options
    localparam logic [7:0] LEN_MIN      = 8'd2;
    localparam logic [5:0] BASE_BYTES   = 6'd20;
    localparam logic [3:0] BASE_WORDS   = 4'd5;

    // found-option flags
    typedef struct packed {
        logic sack;
        logic stamp;
        logic win;
        logic mss;
    } seen_t;

endpackage

// ===== design/tcp_option_parser.sv =====
// tcp option area parser: walks option bytes, one beat per byte
//
// Input channel (in_valid/in_ready) carries one option byte per beat with
// first_byte, last_byte and header_words (read on the first beat). The
// area holds header_words*4-20 bytes; a header with no options is sent as
// one dummy beat and reports parse_ok 0.
// Output channel (out_valid/out_ready) carries one result per header, made
// from the beat that has last_byte set. Beats without last_byte produce no
// output beat.
// Timing: a byte beat is registered at acceptance, and the walk state and
// result register are updated when it leaves the input register; a beat
// with last_byte leaves only once the result slot is free.
// Throughput: one byte per cycle unless a last_byte beat waits for the result slot;
// the walk step is a single byte-wide update between the input and result registers.
// When the receiver stalls, the result register holds; byte beats without
// last_byte keep flowing, and a beat with last_byte waits in the input
// register until the result slot frees.
// Reset clears the walk state and both valid flags, not the stored result fields.
module tcp_option_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  opt_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    input  logic [3:0]  header_words,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        parse_ok,
    output logic [15:0] mss_value,
    output logic        mss_seen,
    output logic [7:0]  window_shift,
    output logic        window_seen,
    output logic [31:0] stamp_value,
    output logic [31:0] stamp_echo,
    output logic        stamp_seen,
    output logic        sack_permitted
);

    // input register
    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_first_reg;
    logic        s1_last_reg;
    logic [3:0]  s1_words_reg;
    logic        s1_advance;

    // walk state
    tcpop_pkg::phase_t phase_reg, phase_next, walk_phase;
    logic [5:0]  left_reg, left_next, walk_left;
    logic [7:0]  kind_reg, walk_kind;
    logic [5:0]  opt_left_reg, walk_opt_left;
    logic [5:0]  opt_size_reg, walk_opt_size;
    logic [63:0] shift_reg, walk_shift;
    tcpop_pkg::seen_t seen_reg, walk_seen;
    logic [15:0] mss_reg, walk_mss;
    logic [7:0]  wscale_reg, walk_wscale;
    logic [63:0] stamp_reg, walk_stamp;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic        ok_reg, ok_next;
    logic [15:0] mss_out_reg, mss_out_next;
    logic [7:0]  wscale_out_reg, wscale_out_next;
    logic [63:0] stamp_out_reg, stamp_out_next;
    tcpop_pkg::seen_t seen_out_reg, seen_out_next;

    // beat moves out of the input register unless it needs a busy result slot
    assign s1_advance = s1_valid_reg &&
                        (!s1_last_reg || !out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg  <= opt_byte;
            s1_first_reg <= first_byte;
            s1_last_reg  <= last_byte;
            s1_words_reg <= header_words;
        end
    end

    // one walk step on the registered byte
    always_comb
    begin
        logic finish;
        finish        = 1'b0;
        walk_phase    = phase_reg;
        walk_left     = left_reg;
        walk_kind     = kind_reg;
        walk_opt_left = opt_left_reg;
        walk_opt_size = opt_size_reg;
        walk_shift    = shift_reg;
        walk_seen     = seen_reg;
        walk_mss      = mss_reg;
        walk_wscale   = wscale_reg;
        walk_stamp    = stamp_reg;

        // start of a header clears everything and loads the area size
        if (s1_first_reg)
        begin
            walk_seen     = '0;
            walk_mss      = '0;
            walk_wscale   = '0;
            walk_stamp    = '0;
            walk_shift    = '0;
            walk_kind     = '0;
            walk_opt_left = '0;
            walk_opt_size = '0;
            if (s1_words_reg > tcpop_pkg::BASE_WORDS)
            begin
                walk_left  = {s1_words_reg, 2'b00} - tcpop_pkg::BASE_BYTES;
                walk_phase = tcpop_pkg::PH_KIND;
            end
            else
            begin
                walk_left  = '0;
                walk_phase = tcpop_pkg::PH_FAIL;
            end
        end

        unique case (walk_phase)
            tcpop_pkg::PH_KIND:
            begin
                if (walk_left == '0)
                begin
                    walk_phase = tcpop_pkg::PH_FAIL;
                end
                else if (s1_byte_reg == tcpop_pkg::KIND_END)
                begin
                    walk_phase = tcpop_pkg::PH_OK;
                end
                else if (s1_byte_reg == tcpop_pkg::KIND_NOP)
                begin
                    walk_left = walk_left - 6'd1;
                    if (walk_left == '0)
                    begin
                        walk_phase = tcpop_pkg::PH_OK;
                    end
                end
                else
                begin
                    walk_kind  = s1_byte_reg;
                    walk_left  = walk_left - 6'd1;
                    walk_phase = (walk_left == '0) ? tcpop_pkg::PH_FAIL
                                                   : tcpop_pkg::PH_LEN;
                end
            end
            tcpop_pkg::PH_LEN:
            begin
                if (s1_byte_reg < tcpop_pkg::LEN_MIN ||
                    {1'b0, s1_byte_reg} > ({3'b000, walk_left} + 9'd1))
                begin
                    walk_phase = tcpop_pkg::PH_FAIL;
                end
                else
                begin
                    // length fits the area, so it is at most 40
                    walk_opt_size = s1_byte_reg[5:0];
                    walk_opt_left = s1_byte_reg[5:0] - tcpop_pkg::LEN_MIN[5:0];
                    walk_left     = walk_left - 6'd1;
                    walk_shift    = '0;
                    if (walk_opt_left == '0)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        walk_phase = tcpop_pkg::PH_VALUE;
                    end
                end
            end
            tcpop_pkg::PH_VALUE:
            begin
                walk_shift    = {walk_shift[55:0], s1_byte_reg};
                walk_opt_left = walk_opt_left - 6'd1;
                if (walk_left != '0)
                begin
                    walk_left = walk_left - 6'd1;
                end
                if (walk_opt_left == '0)
                begin
                    finish = 1'b1;
                end
            end
            default:
            begin
                walk_phase = walk_phase;
            end
        endcase

        // option complete: capture known options at their exact lengths
        if (finish)
        begin
            if (walk_kind == tcpop_pkg::KIND_MSS &&
                walk_opt_size == tcpop_pkg::LEN_MSS)
            begin
                walk_mss      = walk_shift[15:0];
                walk_seen.mss = 1'b1;
            end
            else if (walk_kind == tcpop_pkg::KIND_WSCALE &&
                     walk_opt_size == tcpop_pkg::LEN_WSCALE)
            begin
                walk_wscale   = walk_shift[7:0];
                walk_seen.win = 1'b1;
            end
            else if (walk_kind == tcpop_pkg::KIND_STAMP &&
                     walk_opt_size == tcpop_pkg::LEN_STAMP)
            begin
                walk_stamp      = walk_shift;
                walk_seen.stamp = 1'b1;
            end
            else if (walk_kind == tcpop_pkg::KIND_SACKOK &&
                     walk_opt_size == tcpop_pkg::LEN_SACKOK)
            begin
                walk_seen.sack = 1'b1;
            end
            walk_phase = (walk_left == '0) ? tcpop_pkg::PH_OK : tcpop_pkg::PH_KIND;
        end
    end

    // result on the last byte, and the walk closes after it
    always_comb
    begin
        logic ok;
        ok              = (walk_phase == tcpop_pkg::PH_OK);
        ok_next         = ok;
        seen_out_next   = ok ? walk_seen : '0;
        mss_out_next    = seen_out_next.mss ? walk_mss : '0;
        wscale_out_next = seen_out_next.win ? walk_wscale : '0;
        stamp_out_next  = seen_out_next.stamp ? walk_stamp : '0;
        phase_next      = s1_last_reg ? tcpop_pkg::PH_FAIL : walk_phase;
        left_next       = s1_last_reg ? '0 : walk_left;
        out_valid_next  = out_valid_reg && !out_ready;
        if (s1_advance && s1_last_reg)
        begin
            out_valid_next = 1'b1;
        end
    end

    // walk state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= tcpop_pkg::PH_KIND;
            left_reg     <= '0;
            kind_reg     <= '0;
            opt_left_reg <= '0;
            opt_size_reg <= '0;
            shift_reg    <= '0;
            seen_reg     <= '0;
            mss_reg      <= '0;
            wscale_reg   <= '0;
            stamp_reg    <= '0;
        end
        else if (s1_advance)
        begin
            phase_reg    <= phase_next;
            left_reg     <= left_next;
            kind_reg     <= walk_kind;
            opt_left_reg <= walk_opt_left;
            opt_size_reg <= walk_opt_size;
            shift_reg    <= walk_shift;
            seen_reg     <= walk_seen;
            mss_reg      <= walk_mss;
            wscale_reg   <= walk_wscale;
            stamp_reg    <= walk_stamp;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_last_reg)
        begin
            ok_reg         <= ok_next;
            seen_out_reg   <= seen_out_next;
            mss_out_reg    <= mss_out_next;
            wscale_out_reg <= wscale_out_next;
            stamp_out_reg  <= stamp_out_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign parse_ok       = ok_reg;
    assign mss_value      = mss_out_reg;
    assign mss_seen       = seen_out_reg.mss;
    assign window_shift   = wscale_out_reg;
    assign window_seen    = seen_out_reg.win;
    assign stamp_value    = stamp_out_reg[63:32];
    assign stamp_echo     = stamp_out_reg[31:0];
    assign stamp_seen     = seen_out_reg.stamp;
    assign sack_permitted = seen_out_reg.sack;

endmodule

// ===== design/tcpop_checker.sv =====
// port-level checks for the tcp option parser, bound to the top level
module tcpop_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        parse_ok,
    input logic [15:0] mss_value,
    input logic        mss_seen,
    input logic [7:0]  window_shift,
    input logic        window_seen,
    input logic [31:0] stamp_value,
    input logic [31:0] stamp_echo,
    input logic        stamp_seen,
    input logic        sack_permitted
);

    // stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(parse_ok) &&
        $stable(mss_value) && $stable(stamp_value) && $stable(stamp_echo))
    else $error("result changed while stalled");

    // failed parse reports no options
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !parse_ok |->
        !mss_seen && !window_seen && !stamp_seen && !sack_permitted)
    else $error("option flagged on failed parse");

    // unseen mss and window fields read zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (mss_seen || mss_value == 16'd0) &&
        (window_seen || window_shift == 8'd0))
    else $error("unseen mss or window field not zero");

    // unseen timestamp fields read zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !stamp_seen |-> stamp_value == 32'd0 && stamp_echo == 32'd0)
    else $error("unseen timestamp not zero");

endmodule

bind tcp_option_parser tcpop_checker u_tcpop_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .parse_ok       (parse_ok),
    .mss_value      (mss_value),
    .mss_seen       (mss_seen),
    .window_shift   (window_shift),
    .window_seen    (window_seen),
    .stamp_value    (stamp_value),
    .stamp_echo     (stamp_echo),
    .stamp_seen     (stamp_seen),
    .sack_permitted (sack_permitted)
);

// ===== test/tcp_option_parser_tb.sv =====
// testbench for tcp_option_parser: option areas checked against a local walk model
module tcp_option_parser_tb;

    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_BEATS = 1950;
    localparam int QUIET_FROM   = 2000;
    localparam int QUIET_TO     = 5000;
    localparam int HOLD_AFTER   = 700;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 10;

    // one input beat, one header result
    typedef struct packed {
        logic [7:0] b;
        logic       first;
        logic       last;
        logic [3:0] words;
    } opt_beat_t;

    typedef struct packed {
        logic        ok;
        logic [15:0] mss;
        logic        mss_f;
        logic [7:0]  ws;
        logic        ws_f;
        logic [31:0] tsv;
        logic [31:0] tse;
        logic        ts_f;
        logic        sack;
    } parse_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  opt_byte = 8'd0;
    logic        first_byte = 1'b0;
    logic        last_byte = 1'b0;
    logic [3:0]  header_words = tcpop_pkg::BASE_WORDS;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        parse_ok;
    logic [15:0] mss_value;
    logic        mss_seen;
    logic [7:0]  window_shift;
    logic        window_seen;
    logic [31:0] stamp_value;
    logic [31:0] stamp_echo;
    logic        stamp_seen;
    logic        sack_permitted;

    tcp_option_parser dut (.*);

    // walk model state
    tcpop_pkg::phase_t walk_phase = tcpop_pkg::PH_KIND;
    logic [7:0]  area_left = 8'd0;
    logic [7:0]  cur_kind = 8'd0;
    logic [7:0]  opt_remain = 8'd0;
    logic [7:0]  opt_len = 8'd0;
    logic [63:0] val_acc = 64'd0;
    tcpop_pkg::seen_t opt_flags = '0;
    logic [15:0] mss_hold = 16'd0;
    logic [7:0]  wscale_hold = 8'd0;
    logic [63:0] stamp_hold = 64'd0;

    opt_beat_t   byte_feed[$];
    parse_res_t  pending_results[$];
    logic [7:0]  area_bytes[$];
    parse_res_t  out_res;
    parse_res_t  want_res;
    int          errors = 0;
    int          cycle_cnt = 0;
    int          beats_sent = 0;
    int          directed_beats = 0;
    logic        stall_hold = 1'b0;
    int          stall_cycles = 0;

    // store a completed option when kind and length match a captured one
    function void close_option();
        if (cur_kind == tcpop_pkg::KIND_MSS && opt_len == 8'(tcpop_pkg::LEN_MSS))
        begin
            mss_hold = val_acc[15:0];
            opt_flags.mss = 1'b1;
        end
        else if (cur_kind == tcpop_pkg::KIND_WSCALE &&
                 opt_len == 8'(tcpop_pkg::LEN_WSCALE))
        begin
            wscale_hold = val_acc[7:0];
            opt_flags.win = 1'b1;
        end
        else if (cur_kind == tcpop_pkg::KIND_STAMP &&
                 opt_len == 8'(tcpop_pkg::LEN_STAMP))
        begin
            stamp_hold = val_acc;
            opt_flags.stamp = 1'b1;
        end
        else if (cur_kind == tcpop_pkg::KIND_SACKOK &&
                 opt_len == 8'(tcpop_pkg::LEN_SACKOK))
            opt_flags.sack = 1'b1;
        walk_phase = (area_left == 8'd0) ? tcpop_pkg::PH_OK : tcpop_pkg::PH_KIND;
    endfunction

    // one step of the kind/length/value walk
    function void walk_byte(logic [7:0] b);
        case (walk_phase)
            tcpop_pkg::PH_KIND:
            begin
                if (area_left == 8'd0)
                    walk_phase = tcpop_pkg::PH_FAIL;
                else if (b == tcpop_pkg::KIND_END)
                    walk_phase = tcpop_pkg::PH_OK;
                else if (b == tcpop_pkg::KIND_NOP)
                begin
                    area_left--;
                    if (area_left == 8'd0)
                        walk_phase = tcpop_pkg::PH_OK;
                end
                else
                begin
                    cur_kind = b;
                    area_left--;
                    walk_phase = (area_left == 8'd0) ? tcpop_pkg::PH_FAIL
                                                     : tcpop_pkg::PH_LEN;
                end
            end
            tcpop_pkg::PH_LEN:
            begin
                if (b < tcpop_pkg::LEN_MIN || int'(b) > int'(area_left) + 1)
                    walk_phase = tcpop_pkg::PH_FAIL;
                else
                begin
                    opt_len = b;
                    opt_remain = b - tcpop_pkg::LEN_MIN;
                    area_left--;
                    val_acc = 64'd0;
                    if (opt_remain == 8'd0)
                        close_option();
                    else
                        walk_phase = tcpop_pkg::PH_VALUE;
                end
            end
            tcpop_pkg::PH_VALUE:
            begin
                val_acc = {val_acc[55:0], b};
                opt_remain--;
                if (area_left != 8'd0)
                    area_left--;
                if (opt_remain == 8'd0)
                    close_option();
            end
            default: ;
        endcase
    endfunction

    // advance the model on an accepted beat, queue a result on last_byte
    function void walk_beat(opt_beat_t bt);
        parse_res_t res;
        if (bt.first)
        begin
            opt_flags = '0;
            mss_hold = 16'd0;
            wscale_hold = 8'd0;
            stamp_hold = 64'd0;
            val_acc = 64'd0;
            cur_kind = 8'd0;
            opt_remain = 8'd0;
            opt_len = 8'd0;
            if (bt.words > tcpop_pkg::BASE_WORDS)
            begin
                area_left = 8'(int'(bt.words) * 4 - int'(tcpop_pkg::BASE_BYTES));
                walk_phase = tcpop_pkg::PH_KIND;
            end
            else
            begin
                area_left = 8'd0;
                walk_phase = tcpop_pkg::PH_FAIL;
            end
        end
        walk_byte(bt.b);
        if (bt.last)
        begin
            res = '0;
            if (walk_phase == tcpop_pkg::PH_OK)
            begin
                res.ok = 1'b1;
                if (opt_flags.mss)
                begin
                    res.mss = mss_hold;
                    res.mss_f = 1'b1;
                end
                if (opt_flags.win)
                begin
                    res.ws = wscale_hold;
                    res.ws_f = 1'b1;
                end
                if (opt_flags.stamp)
                begin
                    res.tsv = stamp_hold[63:32];
                    res.tse = stamp_hold[31:0];
                    res.ts_f = 1'b1;
                end
                res.sack = opt_flags.sack;
            end
            pending_results.push_back(res);
            walk_phase = tcpop_pkg::PH_FAIL;
            area_left = 8'd0;
        end
    endfunction

    function void note_failure(string what, parse_res_t want, parse_res_t got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t %s: want ok=%0d mss=%h/%0d ws=%h/%0d ts=%h,%h/%0d sack=%0d",
                     $realtime, what, want.ok, want.mss, want.mss_f, want.ws, want.ws_f,
                     want.tsv, want.tse, want.ts_f, want.sack);
        if (errors <= MAX_REPORTS)
            $display("    got ok=%0d mss=%h/%0d ws=%h/%0d ts=%h,%h/%0d sack=%0d",
                     got.ok, got.mss, got.mss_f, got.ws, got.ws_f,
                     got.tsv, got.tse, got.ts_f, got.sack);
    endfunction

    // byte values that lean toward the extremes
    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(7);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    function void push_beat(logic [7:0] b, bit f, bit l, int w);
        byte_feed.push_back(opt_beat_t'{b, f, l, 4'(w)});
    endfunction

    // append one option that fits in room bytes
    function void add_option(int room);
        int pick;
        int len;
        int cap;
        logic [7:0] kind;
        pick = $urandom_range(9);
        cap = (room < 12) ? room : 12;
        if (pick == 0 || room < 2)
            area_bytes.push_back(tcpop_pkg::KIND_NOP);
        else if (pick == 1 && room >= 4)
        begin
            area_bytes.push_back(tcpop_pkg::KIND_MSS);
            area_bytes.push_back(8'(tcpop_pkg::LEN_MSS));
            area_bytes.push_back(rand_byte());
            area_bytes.push_back(rand_byte());
        end
        else if (pick == 2 && room >= 3)
        begin
            area_bytes.push_back(tcpop_pkg::KIND_WSCALE);
            area_bytes.push_back(8'(tcpop_pkg::LEN_WSCALE));
            area_bytes.push_back(rand_byte());
        end
        else if (pick == 3)
        begin
            area_bytes.push_back(tcpop_pkg::KIND_SACKOK);
            area_bytes.push_back(8'(tcpop_pkg::LEN_SACKOK));
        end
        else if ((pick == 4 || pick == 5) && room >= 10)
        begin
            area_bytes.push_back(tcpop_pkg::KIND_STAMP);
            area_bytes.push_back(8'(tcpop_pkg::LEN_STAMP));
            repeat (8) area_bytes.push_back(rand_byte());
        end
        else if (pick == 6 || pick == 7)
        begin
            // unknown kind to skip, or a known kind at any length up to cap (short ones included)
            if (pick == 6)
            begin
                kind = 8'($urandom_range(5, 255));
                if (kind == tcpop_pkg::KIND_STAMP)
                    kind = 8'd9;
                len = $urandom_range(2, cap);
            end
            else
            begin
                case ($urandom_range(3))
                    0: kind = tcpop_pkg::KIND_MSS;
                    1: kind = tcpop_pkg::KIND_WSCALE;
                    2: kind = tcpop_pkg::KIND_SACKOK;
                    default: kind = tcpop_pkg::KIND_STAMP;
                endcase
                len = $urandom_range(0, cap);
            end
            area_bytes.push_back(kind);
            area_bytes.push_back(8'(len));
            for (int k = 2; k < len; k++)
                area_bytes.push_back(rand_byte());
        end
        else
            area_bytes.push_back(tcpop_pkg::KIND_NOP);
    endfunction

    // queue cnt beats of the area, padding past its end with random bytes
    function void send_area(int words, int cnt, bit with_last);
        for (int k = 0; k < cnt; k++)
            push_beat(k < area_bytes.size() ? area_bytes[k] : rand_byte(), k == 0,
                      with_last && k == cnt - 1, k == 0 ? words : $urandom_range(5, 15));
    endfunction

    // one random header: mostly well formed, the rest damaged in various ways
    function void queue_header();
        int words;
        int n;
        int mode;
        int cnt;
        bit with_last;
        words = ($urandom_range(99) < 8) ? 5 : $urandom_range(6, 15);
        mode = $urandom_range(99);
        area_bytes.delete();
        if (words <= 5)
            push_beat(rand_byte(), 1'b1, 1'b1, words);
        else
        begin
            n = words * 4 - 20;
            if (mode < 8)
                repeat (n) area_bytes.push_back(rand_byte());
            else if (mode < 14)
            begin
                // kind byte with no room left for its length
                while (area_bytes.size() < n - 1)
                    add_option(n - 1 - area_bytes.size());
                area_bytes.push_back(8'($urandom_range(2, 255)));
            end
            else
            begin
                while (area_bytes.size() < n)
                    add_option(n - area_bytes.size());
                if (mode < 20)
                    area_bytes[$urandom_range(n - 1)] = tcpop_pkg::KIND_END;
                else if (mode < 27)
                    area_bytes[$urandom_range(n - 1)] = rand_byte();
            end
            cnt = n;
            with_last = 1'b1;
            if (mode >= 27 && mode < 33)
                cnt = n + $urandom_range(1, 4);
            else if (mode >= 33 && mode < 39)
            begin
                cnt = $urandom_range(1, n - 1);
                with_last = (mode < 37);
            end
            send_area(words, cnt, with_last);
        end
        // stray beats with no header in front
        if (mode >= 95)
            repeat ($urandom_range(1, 3))
                push_beat(rand_byte(), 1'b0, $urandom_range(1), $urandom_range(5, 15));
    endfunction

    function automatic bit idle_now();
        return (cycle_cnt < QUIET_FROM || cycle_cnt >= QUIET_TO) &&
               ($urandom_range(99) < 17);
    endfunction

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // sender: feed beats from the queue, predict on each accepted one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            opt_byte <= 8'd0;
            first_byte <= 1'b0;
            last_byte <= 1'b0;
            header_words <= tcpop_pkg::BASE_WORDS;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                walk_beat(opt_beat_t'{opt_byte, first_byte, last_byte, header_words});
                beats_sent <= beats_sent + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (byte_feed.size() != 0 && !idle_now())
                begin
                    in_valid <= 1'b1;
                    opt_byte <= byte_feed[0].b;
                    first_byte <= byte_feed[0].first;
                    last_byte <= byte_feed[0].last;
                    header_words <= byte_feed[0].words;
                    byte_feed.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // one long receiver hold-off while the sender keeps going
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_hold <= 1'b0;
            stall_cycles <= 0;
        end
        else if (!stall_hold && stall_cycles == 0 && beats_sent >= HOLD_AFTER)
            stall_hold <= 1'b1;
        else if (stall_hold)
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == HOLD_CYCLES - 1)
                stall_hold <= 1'b0;
        end
    end

    // receiver ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !stall_hold && !idle_now();
    end

    // result check against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            out_res = '{parse_ok, mss_value, mss_seen, window_shift, window_seen,
                        stamp_value, stamp_echo, stamp_seen, sack_permitted};
            if (pending_results.size() == 0)
                note_failure("unexpected result", '0, out_res);
            else
            begin
                want_res = pending_results.pop_front();
                if (out_res !== want_res)
                    note_failure("result mismatch", want_res, out_res);
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES)
        begin
            $display("tcp_option_parser_tb NOT OK");
            $finish;
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        // last_byte before any header
        push_beat(tcpop_pkg::KIND_END, 1'b0, 1'b1, 5);
        // header with no options
        push_beat(8'hFF, 1'b1, 1'b1, 5);
        // aligned timestamp
        area_bytes = '{tcpop_pkg::KIND_NOP, tcpop_pkg::KIND_NOP, tcpop_pkg::KIND_STAMP,
                       8'(tcpop_pkg::LEN_STAMP),
                       8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
        send_area(8, 12, 1'b1);
        // mss, window scale, then end of list
        area_bytes = '{tcpop_pkg::KIND_MSS, 8'(tcpop_pkg::LEN_MSS), 8'hFF, 8'hFF,
                       tcpop_pkg::KIND_WSCALE, 8'(tcpop_pkg::LEN_WSCALE), 8'hFF,
                       tcpop_pkg::KIND_END};
        send_area(7, 8, 1'b1);
        // sack permitted, nop, then a kind byte with no length
        area_bytes = '{tcpop_pkg::KIND_SACKOK, 8'(tcpop_pkg::LEN_SACKOK),
                       tcpop_pkg::KIND_NOP, 8'd5};
        send_area(6, 4, 1'b1);
        directed_beats = byte_feed.size();
        while (byte_feed.size() - directed_beats < RANDOM_BEATS)
            queue_header();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_feed.size() != 0 || in_valid)
            @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("tcp_option_parser_tb OK");
        else
            $display("tcp_option_parser_tb NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
design/tcpop_pkg.sv
design/tcp_option_parser.sv
design/tcpop_checker.sv
test/tcp_option_parser_tb.sv
